FILE: hdl/assert_macros.svh
// Assertion macros shared by the ranker RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fsr_pkg.sv
// Package for the fuzzy subsequence top-k ranker: sizes, codes, types, helpers.
// No dependencies; used by every other file of the block except assert_macros.svh.
package fsr_pkg;

  // Sizing
  localparam int TOP_COUNT = 20;
  localparam int QUERY_MAX = 16;
  localparam int ID_BITS   = 12;
  localparam int NAME_MAX  = 255;

  localparam int QBYTES   = 16;  // query storage, two 64-bit registers
  localparam int QIDX_W   = 4;   // byte select into query storage
  localparam int QLEN_W   = 5;
  localparam int SCORE_W  = 13;
  localparam int RANK_OUT_W = 5;
  localparam int NLEN_W   = $clog2(NAME_MAX + 1);
  localparam int RANK_W   = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int CNT_W    = $clog2(TOP_COUNT + 1);

  // Scoring in hundredths
  localparam int MATCH_BASE  = 100;
  localparam int RUN_BONUS   = 50;
  localparam int EMPTY_SCORE = 100;

  // Input command codes
  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_QLOW  = 2'd0;
  localparam logic [1:0] REG_QHIGH = 2'd1;
  localparam logic [1:0] REG_QLEN  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic step_char;   // take one name byte
    logic clear_list;  // empty list, drop name in progress
    logic insert;      // finish name, insert if it qualifies
    logic load_out;    // move next readout entry into output register
  } fsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a new result
    logic rd_last;     // entry being read out is the final one
  } fsr_stat_t;

  // ASCII upper case to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'h20;
    return r;
  endfunction

endpackage

FILE: hdl/fsr_ifs.sv
// Channel interfaces of the ranker: input items, results, configuration writes.
// Depends on fsr_pkg for field widths.
interface fsr_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [7:0]                 character;
  logic                       last_char;
  logic [fsr_pkg::ID_BITS-1:0] candidate_id;

  modport source (output valid, command, character, last_char, candidate_id, input ready);
  modport sink   (input valid, command, character, last_char, candidate_id, output ready);
endinterface

interface fsr_out_if;
  logic                           valid;
  logic                           ready;
  logic [fsr_pkg::ID_BITS-1:0]    entry_id;
  logic [fsr_pkg::SCORE_W-1:0]    entry_score;
  logic [fsr_pkg::RANK_OUT_W-1:0] rank;
  logic                           list_empty;
  logic                           last;

  modport source (output valid, entry_id, entry_score, rank, list_empty, last, input ready);
  modport sink   (input valid, entry_id, entry_score, rank, list_empty, last, output ready);
endinterface

interface fsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fsr_ctrl.sv
// Ranker controller: accepts input transfers and sequences insert and readout.
// Depends on fsr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_command,
  input  logic               in_last_char,
  output logic               in_ready,
  output fsr_pkg::fsr_cmd_t  cmd,
  input  fsr_pkg::fsr_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_INSERT = 3'b010,
    ST_READ   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_command)
            fsr_pkg::CMD_CHAR: begin
              cmd.step_char = 1'b1;
              if (in_last_char) state_nxt = ST_INSERT;
            end
            fsr_pkg::CMD_CLEAR: cmd.clear_list = 1'b1;
            fsr_pkg::CMD_READ:  state_nxt = ST_READ;
            default: ;  // unused code, dropped
          endcase
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.rd_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_NEXT(a_insert_one_cycle, state_r == ST_INSERT, state_r == ST_IDLE, "insert overran")

endmodule

FILE: hdl/fsr_datapath.sv
// Ranker datapath: query registers, per-byte scoring, sorted top list, output register.
// Depends on fsr_pkg, fsr_ifs and assert_macros.svh.
`include "assert_macros.svh"

module fsr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_character,
  input  logic                        in_last_char,
  input  logic [fsr_pkg::ID_BITS-1:0] in_candidate_id,
  input  fsr_pkg::fsr_cmd_t           cmd,
  output fsr_pkg::fsr_stat_t          stat,
  fsr_cfg_if.sink                     cfg_chan,
  fsr_out_if.source                   out_chan
);

  localparam int TC = fsr_pkg::TOP_COUNT;
  localparam int SW = fsr_pkg::SCORE_W;
  localparam int CW = fsr_pkg::CNT_W;
  localparam int RW = fsr_pkg::RANK_W;
  localparam int NW = fsr_pkg::NLEN_W;
  localparam int QW = fsr_pkg::QLEN_W;
  localparam int IW = fsr_pkg::ID_BITS;

  // Query registers
  logic [63:0]   qlow_r, qhigh_r;
  logic [QW-1:0] qlen_r;
  logic [QW-1:0] q_eff;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlow_r  <= '0;
      qhigh_r <= '0;
      qlen_r  <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        fsr_pkg::REG_QLOW:  qlow_r  <= cfg_chan.data;
        fsr_pkg::REG_QHIGH: qhigh_r <= cfg_chan.data;
        fsr_pkg::REG_QLEN:  qlen_r  <= cfg_chan.data[QW-1:0];
        default: ;
      endcase
    end
  end

  assign q_eff = (qlen_r > QW'(fsr_pkg::QUERY_MAX)) ? QW'(fsr_pkg::QUERY_MAX) : qlen_r;

  // Candidate scoring state
  logic [QW-1:0] match_pos_r, match_pos_nxt;
  logic [QW-1:0] run_len_r,   run_len_nxt;
  logic [SW-1:0] score_r,     score_nxt;
  logic [NW-1:0] name_len_r,  name_len_nxt;
  logic [IW-1:0] cand_id_r;
  logic [fsr_pkg::QBYTES*8-1:0] qword;
  logic [7:0]    qbyte;
  logic          qbyte_hit;

  assign qword     = {qhigh_r, qlow_r};
  assign qbyte     = qword[{match_pos_r[fsr_pkg::QIDX_W-1:0], 3'b000} +: 8];
  assign qbyte_hit = fsr_pkg::fold(in_character) == fsr_pkg::fold(qbyte);

  // Greedy subsequence step for one byte
  always_comb begin
    match_pos_nxt = match_pos_r;
    run_len_nxt   = run_len_r;
    score_nxt     = score_r;
    name_len_nxt  = name_len_r;
    if (cmd.clear_list || cmd.insert) begin
      match_pos_nxt = '0;
      run_len_nxt   = '0;
      score_nxt     = '0;
      name_len_nxt  = '0;
    end else if (cmd.step_char) begin
      if (name_len_r < NW'(fsr_pkg::NAME_MAX)) name_len_nxt = name_len_r + 1'b1;
      if (match_pos_r < q_eff) begin
        if (qbyte_hit) begin
          score_nxt     = score_r + SW'(fsr_pkg::MATCH_BASE)
                          + SW'(run_len_r) * SW'(fsr_pkg::RUN_BONUS);
          run_len_nxt   = run_len_r + 1'b1;
          match_pos_nxt = match_pos_r + 1'b1;
        end else begin
          run_len_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r <= '0;
      run_len_r   <= '0;
      score_r     <= '0;
      name_len_r  <= '0;
    end else begin
      match_pos_r <= match_pos_nxt;
      run_len_r   <= run_len_nxt;
      score_r     <= score_nxt;
      name_len_r  <= name_len_nxt;
    end
  end

  // Id travels with the final byte
  always_ff @(posedge clk) begin
    if (cmd.step_char && in_last_char) cand_id_r <= in_candidate_id;
  end

  // Final score: running sum less length penalty, or a fixed score for an empty query
  logic [NW-1:0] penalty;
  logic [SW-1:0] fin_score;
  logic          qualify;

  assign penalty = name_len_r - NW'(q_eff);

  always_comb begin
    if (q_eff == '0) begin
      fin_score = SW'(fsr_pkg::EMPTY_SCORE);
      qualify   = 1'b1;
    end else begin
      fin_score = score_r - SW'(penalty);
      qualify   = (match_pos_r >= q_eff) && (score_r > SW'(penalty));
    end
  end

  // Sorted list with parallel insertion
  logic [IW-1:0] ids_r    [TC];
  logic [SW-1:0] scores_r [TC];
  logic [IW-1:0] ids_nxt    [TC];
  logic [SW-1:0] scores_nxt [TC];
  logic [TC-1:0] keep;  // entry ranks at or above the new score
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_insert;

  assign do_insert = cmd.insert && qualify;

  for (genvar i = 0; i < TC; i++) begin : g_slot
    assign keep[i] = (CW'(i) < cnt_r) && (scores_r[i] >= fin_score);
    if (i == 0) begin : g_head
      always_comb begin
        ids_nxt[i]    = keep[i] ? ids_r[i]    : cand_id_r;
        scores_nxt[i] = keep[i] ? scores_r[i] : fin_score;
      end
    end else begin : g_body
      always_comb begin
        if (keep[i]) begin
          ids_nxt[i]    = ids_r[i];
          scores_nxt[i] = scores_r[i];
        end else if (keep[i-1]) begin
          ids_nxt[i]    = cand_id_r;
          scores_nxt[i] = fin_score;
        end else begin
          ids_nxt[i]    = ids_r[i-1];
          scores_nxt[i] = scores_r[i-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (do_insert) begin
        ids_r[i]    <= ids_nxt[i];
        scores_r[i] <= scores_nxt[i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear_list) cnt_nxt = '0;
    else if (do_insert && (cnt_r < CW'(TC))) cnt_nxt = cnt_r + 1'b1;
  end

  // Readout pointer and output register
  logic [RW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_last;
  logic          out_valid_r;
  logic [IW-1:0] out_id_r;
  logic [SW-1:0] out_score_r;
  logic [fsr_pkg::RANK_OUT_W-1:0] out_rank_r;
  logic          out_empty_r, out_last_r;

  assign rd_last       = (cnt_r == '0) || ((CW'(rd_idx_r) + 1'b1) == cnt_r);
  assign stat.rd_last  = rd_last;
  assign stat.out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.load_out) rd_idx_nxt = rd_last ? '0 : rd_idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (cmd.load_out)        out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cnt_r == '0) begin
        out_id_r    <= '0;
        out_score_r <= '0;
        out_rank_r  <= '0;
        out_empty_r <= 1'b1;
      end else begin
        out_id_r    <= ids_r[rd_idx_r];
        out_score_r <= scores_r[rd_idx_r];
        out_rank_r  <= fsr_pkg::RANK_OUT_W'(rd_idx_r);
        out_empty_r <= 1'b0;
      end
      out_last_r <= rd_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.entry_id    = out_id_r;
  assign out_chan.entry_score = out_score_r;
  assign out_chan.rank        = out_rank_r;
  assign out_chan.list_empty  = out_empty_r;
  assign out_chan.last        = out_last_r;

  `ASSERT_IMPL(a_no_overwrite, cmd.load_out, !out_valid_r || out_chan.ready, "result overwritten")
  `ASSERT_NEXT(a_clear_empties, cmd.clear_list, cnt_r == '0, "clear left entries")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(TC), "list count out of range")

endmodule

FILE: hdl/fuzzy_subsequence_top_k_ranker.sv
// Fuzzy subsequence top-k ranker, top level.
// Channels: in_chan (command, character, last_char, candidate_id), out_chan
// (entry_id, entry_score, rank, list_empty, last), cfg_chan (index, data),
// all valid/ready; a transfer happens when valid and ready are both high.
// cfg_chan is always ready; write the query registers only while idle.
// Name bytes are taken while the controller is idle; the final byte of a name moves
// it to the insert state, which does the compare-and-shift insertion into the list.
// A clear is handled while idle. A readout gives one result per list entry (one
// result for an empty list); the read state loads each into the output register when
// that register is free, and with the receiver ready one result leaves per cycle.
// The next input is taken right after the last load, even while that last
// result still waits in the output register.
// A stalled receiver holds the readout at the output register; the list
// pointer advances only when the register frees up.
// Reset (rst_n low at a clock edge) empties the list, drops any name in
// progress and clears the query; list entries themselves are not cleared.
// Depends on fsr_pkg, fsr_ifs, fsr_ctrl and fsr_datapath.
module fuzzy_subsequence_top_k_ranker (
  input  logic       clk,
  input  logic       rst_n,
  fsr_in_if.sink     in_chan,
  fsr_out_if.source  out_chan,
  fsr_cfg_if.sink    cfg_chan
);

  fsr_pkg::fsr_cmd_t  cmd;
  fsr_pkg::fsr_stat_t stat;
  logic               in_ready;

  assign in_chan.ready = in_ready;

  // Sequencing
  fsr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_command   (in_chan.command),
    .in_last_char (in_chan.last_char),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Scoring, list and output register
  fsr_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_character    (in_chan.character),
    .in_last_char    (in_chan.last_char),
    .in_candidate_id (in_chan.candidate_id),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_chan        (cfg_chan),
    .out_chan        (out_chan)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for fuzzy_subsequence_top_k_ranker: directed and random name streams,
// scored and ranked by an in-bench predictor and checked field by field.
// Depends on fsr_pkg, the channel interfaces in fsr_ifs and the ranker RTL.
module tb;

  localparam int IDW  = fsr_pkg::ID_BITS;
  localparam int SCW  = fsr_pkg::SCORE_W;
  localparam int RKW  = fsr_pkg::RANK_OUT_W;
  localparam int QLW  = fsr_pkg::QLEN_W;
  localparam int TOPN = fsr_pkg::TOP_COUNT;
  localparam int QMAX = fsr_pkg::QUERY_MAX;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET   = 430;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  // Directed 16-byte query with bytes on both sides of the A-Z fold range
  localparam logic [63:0] EDGE_QUERY_LO = 64'hFF00_7B60_5B40_5A61;
  localparam logic [63:0] EDGE_QUERY_HI = 64'h417A_807E_2037_516D;

  typedef struct packed {
    logic [1:0]     command;
    logic [7:0]     character;
    logic           last_char;
    logic [IDW-1:0] candidate_id;
  } name_item_t;

  typedef struct packed {
    logic [IDW-1:0] entry_id;
    logic [SCW-1:0] entry_score;
    logic [RKW-1:0] rank;
    logic           list_empty;
    logic           last;
  } rank_entry_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst_n;

  fsr_in_if  in_chan();
  fsr_out_if out_chan();
  fsr_cfg_if cfg_chan();

  fuzzy_subsequence_top_k_ranker i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predictor copy of the query registers
  logic [63:0]    query_low;
  logic [63:0]    query_high;
  logic [QLW-1:0] query_len;

  // Predictor copy of the name in progress and the ranking
  int unsigned    match_pos;
  int unsigned    run_len;
  int unsigned    run_score;
  int unsigned    name_len;
  int unsigned    ranked_count;
  logic [IDW-1:0] ranked_ids    [TOPN];
  logic [SCW-1:0] ranked_scores [TOPN];

  name_item_t  pending_items[$];
  rank_entry_t expected_ranks[$];
  logic [7:0]  name_buf[$];
  name_item_t  driven_item;

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  bit          failed       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] lower_ascii(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int unsigned active_query_len();
    return (query_len > QMAX) ? QMAX : query_len;
  endfunction

  function automatic logic [7:0] query_char(int unsigned i);
    logic [63:0] w;
    w = (i < 8) ? query_low : query_high;
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic void drop_name();
    match_pos = 0;
    run_len   = 0;
    run_score = 0;
    name_len  = 0;
  endfunction

  // Stable insert: a new entry goes after every entry with an equal or higher score
  function automatic void rank_insert(logic [IDW-1:0] id, int unsigned score);
    int unsigned pos;
    int unsigned stop;
    int unsigned k;
    pos = 0;
    while (pos < ranked_count && ranked_scores[pos] >= score) pos++;
    if (pos >= TOPN) return;
    stop = (ranked_count < TOPN) ? ranked_count : TOPN - 1;
    for (k = stop; k > pos; k--) begin
      ranked_ids[k]    = ranked_ids[k - 1];
      ranked_scores[k] = ranked_scores[k - 1];
    end
    ranked_ids[pos]    = id;
    ranked_scores[pos] = SCW'(score);
    if (ranked_count < TOPN) ranked_count++;
  endfunction

  function automatic void score_item(name_item_t it);
    int unsigned q;
    int unsigned penalty;
    int unsigned k;
    rank_entry_t entry;
    q = active_query_len();
    case (it.command)
      fsr_pkg::CMD_CHAR: begin
        if (name_len < fsr_pkg::NAME_MAX) name_len++;
        if (match_pos < q) begin
          if (lower_ascii(it.character) == lower_ascii(query_char(match_pos))) begin
            run_score += fsr_pkg::MATCH_BASE + fsr_pkg::RUN_BONUS * run_len;
            run_len++;
            match_pos++;
          end else begin
            run_len = 0;
          end
        end
        if (it.last_char) begin
          if (q == 0) begin
            rank_insert(it.candidate_id, fsr_pkg::EMPTY_SCORE);
          end else if (match_pos >= q) begin
            // unsigned on purpose: a name shorter than the query never scores
            penalty = name_len - q;
            if (run_score > penalty) rank_insert(it.candidate_id, run_score - penalty);
          end
          drop_name();
        end
      end
      fsr_pkg::CMD_CLEAR: begin
        ranked_count = 0;
        drop_name();
      end
      fsr_pkg::CMD_READ: begin
        if (ranked_count == 0) begin
          entry            = '0;
          entry.list_empty = 1'b1;
          entry.last       = 1'b1;
          expected_ranks   = {expected_ranks, entry};
        end else begin
          for (k = 0; k < ranked_count; k++) begin
            entry.entry_id    = ranked_ids[k];
            entry.entry_score = ranked_scores[k];
            entry.rank        = RKW'(k);
            entry.list_empty  = 1'b0;
            entry.last        = (k + 1 == ranked_count);
            expected_ranks    = {expected_ranks, entry};
          end
        end
      end
      default: ;  // unused command code is ignored
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    name_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        score_item(driven_item);
        items_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt         = pending_items.pop_front();
          driven_item = nxt;
          in_chan.command      <= nxt.command;
          in_chan.character    <= nxt.character;
          in_chan.last_char    <= nxt.last_char;
          in_chan.candidate_id <= nxt.candidate_id;
          in_chan.valid        <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall pattern switches between open, coin-flip and bursty
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode     = RX_OPEN;
  int unsigned mode_cycles = 0;
  int unsigned stall_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (mode_cycles == 0) begin
        rx_mode     = rx_mode_t'($urandom_range(0, 2));
        mode_cycles = $urandom_range(20, 120);
      end
      mode_cycles--;
      case (rx_mode)
        RX_OPEN: out_chan.ready <= 1'b1;
        RX_COIN: out_chan.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else begin
            stall_left = $urandom_range(1, 10);
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    rank_entry_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_ranks.size() == 0) begin
        $error("result with no readout pending: entry_id %0d rank %0d",
               out_chan.entry_id, out_chan.rank);
        failed = 1'b1;
      end else begin
        want = expected_ranks.pop_front();
        check_field("entry_id",    16'(want.entry_id),    16'(out_chan.entry_id));
        check_field("entry_score", 16'(want.entry_score), 16'(out_chan.entry_score));
        check_field("rank",        16'(want.rank),        16'(out_chan.rank));
        check_field("list_empty",  16'(want.list_empty),  16'(out_chan.list_empty));
        check_field("last",        16'(want.last),        16'(out_chan.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run after too many cycles without any transfer
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
          || (cfg_chan.valid && cfg_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] cmd, logic [7:0] ch, logic lc, logic [IDW-1:0] id);
    name_item_t it;
    it = '{cmd, ch, lc, id};
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  // Non-name commands carry random junk in the unused fields
  task automatic queue_cmd(logic [1:0] cmd);
    queue_item(cmd, 8'($urandom), 1'($urandom), IDW'($urandom));
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    logic [7:0] f;
    f = lower_ascii(c);
    if (f >= 8'h61 && f <= 8'h7A && $urandom_range(0, 1) == 1) return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] filler_byte();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) c = 8'($urandom_range(0, 255));
    else c = any_case(8'(8'h61 + $urandom_range(0, 25)));
    return c;
  endfunction

  function automatic logic [63:0] query_word();
    logic [63:0] w;
    int i;
    if ($urandom_range(0, 3) == 0) begin
      w = {$urandom, $urandom};
    end else begin
      for (i = 0; i < 8; i++) w[i * 8 +: 8] = filler_byte();
    end
    return w;
  endfunction

  // Query chars in order, random case, with sparse filler so runs form
  task automatic make_matching_name();
    int unsigned i;
    name_buf.delete();
    for (i = 0; i < active_query_len(); i++) begin
      while ($urandom_range(0, 3) == 0) name_buf = {name_buf, filler_byte()};
      name_buf = {name_buf, any_case(query_char(i))};
    end
    repeat ($urandom_range(0, 3)) name_buf = {name_buf, filler_byte()};
    if (name_buf.size() == 0) name_buf = {name_buf, filler_byte()};
  endtask

  // Short name biased toward query chars, so partial matches are common
  task automatic make_random_name();
    int unsigned q;
    name_buf.delete();
    q = active_query_len();
    repeat ($urandom_range(1, 12)) begin
      if (q > 0 && $urandom_range(0, 1) == 1)
        name_buf = {name_buf, any_case(query_char($urandom_range(0, q - 1)))};
      else
        name_buf = {name_buf, filler_byte()};
    end
  endtask

  // Send name_buf; readouts, clears and unused codes land mid-name now and then
  task automatic queue_name(logic [IDW-1:0] id, bit close);
    int unsigned i;
    logic lc;
    for (i = 0; i < name_buf.size(); i++) begin
      if (i > 0 && $urandom_range(0, 29) == 0) queue_cmd(fsr_pkg::CMD_READ);
      if (i > 0 && $urandom_range(0, 149) == 0) queue_cmd(fsr_pkg::CMD_CLEAR);
      if ($urandom_range(0, 39) == 0) queue_cmd(CMD_UNUSED);
      lc = close && (i == name_buf.size() - 1);
      queue_item(fsr_pkg::CMD_CHAR, name_buf[i], lc, lc ? id : IDW'($urandom));
    end
  endtask

  // Send name_buf as one uninterrupted, closed name
  task automatic queue_plain_name(logic [IDW-1:0] id);
    int unsigned i;
    logic lc;
    for (i = 0; i < name_buf.size(); i++) begin
      lc = (i == name_buf.size() - 1);
      queue_item(fsr_pkg::CMD_CHAR, name_buf[i], lc, lc ? id : IDW'($urandom));
    end
  endtask

  // Sender holds off until every transfer is in and every readout result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (items_taken != items_queued || expected_ranks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called at a rising edge while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_chan.ready);
    case (idx)
      fsr_pkg::REG_QLOW:  query_low  = value;
      fsr_pkg::REG_QHIGH: query_high = value;
      fsr_pkg::REG_QLEN:  query_len  = value[QLW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_query(logic [63:0] lo, logic [63:0] hi, logic [QLW-1:0] len);
    write_reg(fsr_pkg::REG_QLOW, lo);
    write_reg(fsr_pkg::REG_QHIGH, hi);
    write_reg(fsr_pkg::REG_QLEN, 64'(len));
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic random_phase();
    int unsigned pick;
    logic [QLW-1:0] len;
    wait_drained();
    pick = $urandom_range(0, 9);
    if (pick == 0)     len = 0;
    else if (pick < 6) len = QLW'($urandom_range(1, 4));
    else if (pick < 9) len = QLW'($urandom_range(5, QMAX));
    else               len = QLW'($urandom_range(QMAX + 1, 31));
    load_query(query_word(), query_word(), len);
    @(negedge clk);
    if ($urandom_range(0, 4) == 0) queue_cmd(fsr_pkg::CMD_CLEAR);
    repeat ($urandom_range(3, 9)) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        make_matching_name();
      end else if (pick < 8) begin
        // one random byte dropped, possibly a query char
        make_matching_name();
        if (name_buf.size() > 1) name_buf.delete($urandom_range(0, name_buf.size() - 1));
      end else begin
        make_random_name();
      end
      queue_name(IDW'($urandom), 1'b1);
    end
    queue_cmd(fsr_pkg::CMD_READ);
    // leave a name open so the next query takes over mid-name
    if ($urandom_range(0, 3) == 0) begin
      make_matching_name();
      queue_name(IDW'($urandom), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.command      = fsr_pkg::CMD_CHAR;
    in_chan.character    = '0;
    in_chan.last_char    = 1'b0;
    in_chan.candidate_id = '0;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = fsr_pkg::REG_QLOW;
    cfg_chan.data        = '0;
    query_low  = '0;
    query_high = '0;
    query_len  = '0;
    ranked_count = 0;
    drop_name();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty query: empty readout, ignored code, ties at the fixed score, clear
    @(negedge clk);
    queue_item(fsr_pkg::CMD_READ, 8'h00, 1'b0, '0);
    queue_item(CMD_UNUSED, 8'hFF, 1'b1, '1);
    queue_item(fsr_pkg::CMD_CHAR, 8'hFF, 1'b1, '1);
    queue_item(fsr_pkg::CMD_CHAR, 8'h00, 1'b1, '0);
    queue_item(fsr_pkg::CMD_READ, 8'hFF, 1'b1, '1);
    queue_item(fsr_pkg::CMD_CLEAR, 8'h00, 1'b0, '0);
    queue_item(fsr_pkg::CMD_READ, 8'h00, 1'b0, '0);

    // Full-length query matched in one run: top score, case folded
    wait_drained();
    load_query(EDGE_QUERY_LO, EDGE_QUERY_HI, QLW'(QMAX));
    @(negedge clk);
    for (i = 0; i < QMAX; i++)
      queue_item(fsr_pkg::CMD_CHAR, any_case(query_char(i)), i == QMAX - 1, IDW'(12'h5A5));
    queue_item(fsr_pkg::CMD_READ, 8'h00, 1'b0, '0);

    // Penalty down to the lowest listed score
    wait_drained();
    load_query(query_word(), query_word(), QLW'(1));
    @(negedge clk);
    name_buf.delete();
    name_buf = {name_buf, any_case(query_char(0))};
    repeat (99) name_buf = {name_buf, filler_byte()};
    queue_plain_name(IDW'($urandom));
    queue_cmd(fsr_pkg::CMD_READ);

    // Name past the length limit: penalty saturates
    wait_drained();
    load_query(query_word(), query_word(), QLW'(4));
    @(negedge clk);
    name_buf.delete();
    for (i = 0; i < 4; i++) name_buf = {name_buf, any_case(query_char(i))};
    repeat (fsr_pkg::NAME_MAX + 1) name_buf = {name_buf, filler_byte()};
    queue_plain_name(IDW'($urandom));
    queue_cmd(fsr_pkg::CMD_READ);

    // Random phases, mostly well-formed names against changing queries
    while (items_queued < ITEM_TARGET) random_phase();

    // Final readout, then drain
    wait_drained();
    @(negedge clk);
    queue_cmd(fsr_pkg::CMD_READ);
    wait_drained();

    if (!failed)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/fsr_pkg.sv
hdl/fsr_ifs.sv
hdl/fsr_ctrl.sv
hdl/fsr_datapath.sv
hdl/fuzzy_subsequence_top_k_ranker.sv
sim/tb.sv
